// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pla check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define PLA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pla check failed: next-cycle implication");

`endif

// File: hw/rtl/pla_pkg.sv
package pla_pkg;

  localparam int COL_W = 6;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_code;
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] span_end;
    logic             last;
  } out_item_t;

  // result kinds
  localparam logic [2:0] KIND_WITHDRAW     = 3'd0;
  localparam logic [2:0] KIND_WITHDRAW_ONE = 3'd1;
  localparam logic [2:0] KIND_CHAR         = 3'd2;
  localparam logic [2:0] KIND_DONE         = 3'd3;
  localparam logic [2:0] KIND_DONE_EXT     = 3'd4;
  localparam logic [2:0] KIND_BEEP         = 3'd5;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic CFG_LINE_LENGTH  = 1'b1;

  localparam logic [15:0]      TIMEOUT_RESET  = 16'd7001;
  localparam logic [COL_W-1:0] LINE_LEN_RESET = 6'd32;
  localparam logic [COL_W-1:0] LINE_LEN_MIN   = 6'd8;
  localparam logic [15:0]      TICK_SAT       = 16'hFFFF;

  // byte codes
  localparam logic [7:0] BYTE_BEL    = 8'h07;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_LPAREN = 8'h28;
  localparam logic [7:0] BYTE_RPAREN = 8'h29;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] BYTE_HIGH   = 8'h80;

  // escape phases
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_ONE  = 2'd1;
  localparam logic [1:0] ESC_TWO  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAB,
    S_RENEW,
    S_WITHDRAW,
    S_BEEP,
    S_PRINT_RD,
    S_PRINT_CH,
    S_DONE,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ESC_ARG,
    ACT_SKIP,
    ACT_ESC,
    ACT_BS,
    ACT_BEEP,
    ACT_LF,
    ACT_TAB,
    ACT_UTF8,
    ACT_CHAR,
    ACT_TICK
  } act_t;

endpackage

// File: hw/rtl/printer_line_assembler.sv
// Printer line assembler: takes received terminal bytes and 1 ms ticks (op 1) and keeps one
// line of text in a small line memory, sending withdraw, beep, per-character print, print-done
// and print-done-with-extend items. A tab writes one memory entry per cycle (up to eight), and
// a print run reads the line memory through its single registered read port, one character
// at a time, behind a one-entry output register; it waits whenever the output side stalls.
// in_ready is high only between items. Configuration writes (index 0 idle timeout in ticks,
// index 1 line length) take effect at once.
module printer_line_assembler import pla_pkg::*; #(
  parameter int LINE_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(LINE_CHARS);
  localparam logic [COL_W-1:0] MAX_LEN = COL_W'(LINE_CHARS);

  // configuration
  logic [15:0]      idle_timeout;
  logic [COL_W-1:0] line_length;

  // line state
  logic [7:0]       line_mem [LINE_CHARS];
  logic [7:0]       rdata;
  logic [COL_W-1:0] cursor, cursor_next;
  logic [COL_W-1:0] printed_left, printed_left_next;
  logic             idle, idle_next;
  logic             protect, protect_next;
  logic             hold, hold_next;
  logic [1:0]       esc_phase, esc_phase_next;
  logic [2:0]       skip_cnt, skip_cnt_next;
  logic [15:0]      tick_cnt, tick_cnt_next;

  // sequencer registers
  state_t           state, state_next;
  logic             need_nl, need_nl_next;
  logic             cr_pend, cr_pend_next;
  logic             print_pend, print_pend_next;
  logic             ext, ext_next;
  logic [2:0]       wd_kind, wd_kind_next;
  logic [COL_W-1:0] tab_target, tab_target_next;
  logic [COL_W-1:0] pidx, pidx_next;

  // combinational helpers
  act_t             act;
  logic [7:0]       b;
  logic [COL_W-1:0] len;
  logic [COL_W-1:0] cursor_dec;
  logic             bs_renew;
  logic [15:0]      tick_lim;
  logic [15:0]      tick_inc;
  logic             tick_fire;
  logic [COL_W:0]   tab_raw;
  logic [COL_W-1:0] tab_calc;
  logic             tab_more;
  logic             full;
  logic             print_now;
  logic [2:0]       lead_ones;
  logic             emit_ok;
  logic             emit;
  out_item_t        emit_item;
  logic             mem_we;
  logic [7:0]       mem_wdata;

  assign b         = in_item.rx_byte;
  assign in_ready  = (state == S_IDLE);
  assign emit_ok   = !out_valid || out_ready;

  always_comb begin
    if (line_length < LINE_LEN_MIN) begin
      len = LINE_LEN_MIN;
    end else if (line_length > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = line_length;
    end
  end

  assign cursor_dec = (cursor != '0) ? cursor - 1'b1 : cursor;
  assign bs_renew   = cursor_dec < printed_left;
  assign tick_lim   = (idle_timeout == '0) ? 16'd1 : idle_timeout;
  assign tick_inc   = (tick_cnt != TICK_SAT) ? tick_cnt + 16'd1 : tick_cnt;
  assign tick_fire  = !idle && (tick_inc >= tick_lim);
  // next tab stop of 8, clamped to the line length
  assign tab_raw    = {1'b0, cursor[COL_W-1:3], 3'b000} + (COL_W+1)'(8);
  assign tab_calc   = (tab_raw > {1'b0, len}) ? len : tab_raw[COL_W-1:0];
  assign tab_more   = ({1'b0, cursor} + (COL_W+1)'(1)) < {1'b0, tab_target};
  assign full       = cursor >= len;
  assign print_now  = (need_nl && !idle) || full;

  // continuation count of a utf-8 lead byte: ones below the top bit
  always_comb begin
    logic run;
    lead_ones = '0;
    run = 1'b1;
    for (int i = 6; i >= 0; i--) begin
      if (run && b[i]) begin
        lead_ones = lead_ones + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_item.op == OP_TICK) begin
      act = ACT_TICK;
    end else if (esc_phase != ESC_NONE) begin
      act = ACT_ESC_ARG;
    end else if (skip_cnt != '0) begin
      act = ACT_SKIP;
    end else if (b == BYTE_ESC) begin
      act = ACT_ESC;
    end else if (b == BYTE_BS) begin
      act = ACT_BS;
    end else if (b == BYTE_BEL) begin
      act = ACT_BEEP;
    end else if (b == BYTE_LF) begin
      act = ACT_LF;
    end else if (b == BYTE_TAB) begin
      act = ACT_TAB;
    end else if (b < BYTE_SPACE) begin
      act = ACT_NONE;
    end else if (b >= BYTE_HIGH) begin
      act = ACT_UTF8;
    end else begin
      act = ACT_CHAR;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (act)
            ACT_BS:   state_next = bs_renew ? S_RENEW : S_FINISH;
            ACT_BEEP: state_next = S_BEEP;
            ACT_LF:   state_next = S_RENEW;
            ACT_UTF8: state_next = S_RENEW;
            ACT_CHAR: state_next = S_RENEW;
            ACT_TAB:  state_next = S_TAB;
            ACT_TICK: state_next = tick_fire ? S_PRINT_RD : S_FINISH;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_TAB:      state_next = tab_more ? S_TAB : S_RENEW;
      S_RENEW: begin
        if (idle) begin
          state_next = S_WITHDRAW;
        end else begin
          state_next = print_now ? S_PRINT_RD : S_FINISH;
        end
      end
      S_WITHDRAW: begin
        if (emit_ok) begin
          state_next = print_pend ? S_PRINT_RD : S_FINISH;
        end
      end
      S_BEEP:     state_next = emit_ok ? S_FINISH : S_BEEP;
      S_PRINT_RD: state_next = (pidx < cursor) ? S_PRINT_CH : S_DONE;
      S_PRINT_CH: state_next = emit_ok ? S_PRINT_RD : S_PRINT_CH;
      S_DONE:     state_next = emit_ok ? S_FINISH : S_DONE;
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and result items
  always_comb begin
    cursor_next       = cursor;
    printed_left_next = printed_left;
    idle_next         = idle;
    protect_next      = protect;
    hold_next         = hold;
    esc_phase_next    = esc_phase;
    skip_cnt_next     = skip_cnt;
    tick_cnt_next     = tick_cnt;
    need_nl_next      = need_nl;
    cr_pend_next      = cr_pend;
    print_pend_next   = print_pend;
    ext_next          = ext;
    wd_kind_next      = wd_kind;
    tab_target_next   = tab_target;
    pidx_next         = pidx;
    mem_we            = 1'b0;
    mem_wdata         = BYTE_SPACE;
    emit              = 1'b0;
    emit_item         = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          need_nl_next = 1'b0;
          cr_pend_next = 1'b0;
          ext_next     = 1'b0;
          pidx_next    = printed_left;
          case (act)
            ACT_ESC_ARG: begin
              if (esc_phase == ESC_ONE && (b == BYTE_LPAREN || b == BYTE_RPAREN)) begin
                esc_phase_next = ESC_TWO;
              end else begin
                esc_phase_next = ESC_NONE;
              end
            end
            ACT_SKIP: skip_cnt_next = skip_cnt - 3'd1;
            ACT_ESC:  esc_phase_next = ESC_ONE;
            ACT_BS: begin
              cursor_next = cursor_dec;
              if (bs_renew) begin
                printed_left_next = '0;
                need_nl_next      = 1'b1;
                if (cursor_dec != '0) begin
                  hold_next = 1'b1;
                end else begin
                  protect_next = 1'b1;
                end
              end
            end
            ACT_LF: begin
              if (cursor != '0 || !protect) begin
                need_nl_next = 1'b1;
                cr_pend_next = 1'b1;
              end else begin
                protect_next = 1'b0;
              end
            end
            ACT_TAB:  tab_target_next = tab_calc;
            ACT_UTF8: begin
              skip_cnt_next = lead_ones;
              mem_wdata     = BYTE_DEL;
              mem_we        = cursor < len;
            end
            ACT_CHAR: begin
              mem_wdata = b;
              mem_we    = cursor < len;
            end
            ACT_TICK: begin
              if (!idle) begin
                if (tick_fire) begin
                  tick_cnt_next = '0;
                  idle_next     = 1'b1;
                  ext_next      = 1'b1;
                end else begin
                  tick_cnt_next = tick_inc;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_TAB: begin
        mem_wdata = tab_more ? BYTE_SPACE : BYTE_TAB;
        mem_we    = cursor < len;
      end
      S_RENEW: begin
        tick_cnt_next   = '0;
        pidx_next       = printed_left;
        print_pend_next = print_now;
        if (idle) begin
          idle_next    = 1'b0;
          wd_kind_next = need_nl ? KIND_WITHDRAW_ONE : KIND_WITHDRAW;
          if (need_nl) begin
            hold_next = 1'b0;
          end
        end
        if (protect && cursor != '0) begin
          protect_next = 1'b0;
        end
        if (full) begin
          protect_next = 1'b1;
          cr_pend_next = 1'b1;
        end
      end
      S_WITHDRAW: begin
        emit           = emit_ok;
        emit_item.kind = wd_kind;
        emit_item.last = !print_pend;
      end
      S_BEEP: begin
        emit           = emit_ok;
        emit_item.kind = KIND_BEEP;
        emit_item.last = 1'b1;
      end
      S_PRINT_CH: begin
        emit                = emit_ok;
        emit_item.kind      = KIND_CHAR;
        emit_item.char_code = rdata;
        emit_item.column    = pidx;
        if (emit_ok) begin
          pidx_next = pidx + 1'b1;
        end
      end
      S_DONE: begin
        emit               = emit_ok;
        emit_item.kind     = ext ? KIND_DONE_EXT : KIND_DONE;
        emit_item.column   = printed_left;
        emit_item.span_end = cursor;
        emit_item.last     = 1'b1;
        if (emit_ok) begin
          hold_next = 1'b0;
          if (!hold) begin
            printed_left_next = cursor;
          end
        end
      end
      S_FINISH: begin
        if (cr_pend) begin
          printed_left_next = '0;
          cursor_next       = '0;
        end
      end
      default: ;
    endcase

    if (mem_we) begin
      cursor_next = cursor + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[cursor[IDX_W-1:0]] <= mem_wdata;
    end
    if (state == S_PRINT_RD) begin
      rdata <= line_mem[pidx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
      line_length  <= LINE_LEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDLE_TIMEOUT) begin
        idle_timeout <= cfg_data;
      end else begin
        line_length <= cfg_data[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cursor       <= '0;
      printed_left <= '0;
      idle         <= 1'b1;
      protect      <= 1'b0;
      hold         <= 1'b0;
      esc_phase    <= ESC_NONE;
      skip_cnt     <= '0;
      tick_cnt     <= '0;
      need_nl      <= 1'b0;
      cr_pend      <= 1'b0;
      print_pend   <= 1'b0;
      ext          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      printed_left <= printed_left_next;
      idle         <= idle_next;
      protect      <= protect_next;
      hold         <= hold_next;
      esc_phase    <= esc_phase_next;
      skip_cnt     <= skip_cnt_next;
      tick_cnt     <= tick_cnt_next;
      need_nl      <= need_nl_next;
      cr_pend      <= cr_pend_next;
      print_pend   <= print_pend_next;
      ext          <= ext_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wd_kind    <= wd_kind_next;
    tab_target <= tab_target_next;
    pidx       <= pidx_next;
    if (emit) begin
      out_item <= emit_item;
    end
  end

endmodule

// File: hw/rtl/pla_checker.sv
`include "assert_macros.svh"

module pla_checker import pla_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic [2:0] kind;
  logic       in_take;
  logic       in_is_tick;

  assign kind       = out_item.kind;
  assign in_take    = in_valid && in_ready;
  assign in_is_tick = (in_item.op == OP_TICK);

  // a stalled result item holds
  `PLA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))
  // every accepted item keeps the block busy in the cycle after it is taken
  `PLA_ASSERT_NXT(a_busy_after_take, clk, rst, in_take, !in_ready)
  // a print char is never the final result of an item
  `PLA_ASSERT_IMP(a_char_not_last, clk, rst, out_valid && kind == KIND_CHAR, !out_item.last)
  // non-print kinds (withdraw and beep) carry no character, column or span
  `PLA_ASSERT_IMP(a_kind_fields, clk, rst, out_valid && (kind == KIND_WITHDRAW || kind == KIND_WITHDRAW_ONE || kind == KIND_BEEP), out_item.char_code == 8'd0 && out_item.span_end == '0 && out_item.column == '0)
  // a valid result item only ever carries a defined kind
  `PLA_ASSERT_IMP(a_kind_range, clk, rst, out_valid || (in_take && in_is_tick), !out_valid || kind <= KIND_BEEP)

endmodule

bind printer_line_assembler pla_checker u_pla_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// File: sim/printer_line_assembler_test.sv
`timescale 1ns / 100ps

module printer_line_assembler_test;
  import pla_pkg::*;

  localparam int LINE_CHARS = 32;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 24;
  localparam int NUM_PHASES = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_IDLE_TIMEOUT;
  logic [15:0] cfg_data = '0;

  always #1 clk = ~clk;

  printer_line_assembler #(.LINE_CHARS(LINE_CHARS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // line state as the block should hold it
  logic [7:0]  line_mem [LINE_CHARS];
  logic [5:0]  line_cursor = '0;
  logic [5:0]  printed_mark = '0;
  bit          line_idle = 1'b1;
  bit          lf_guard = 1'b0;
  bit          keep_mark = 1'b0;
  logic [1:0]  esc_state = ESC_NONE;
  logic [2:0]  skip_left = '0;
  logic [15:0] quiet_ticks = '0;
  logic [15:0] timeout_ticks = TIMEOUT_RESET;
  logic [5:0]  line_len_reg = LINE_LEN_RESET;

  out_item_t step_events[$];
  out_item_t events_due[$];
  out_item_t head_event;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  fast_phase = 1'b0;
  int  hold_asked = 0;
  int  hold_taken = 0;
  int  stall_left = 0;

  logic [15:0] phase_timeout [NUM_PHASES] = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd6};
  logic [5:0]  phase_len [NUM_PHASES] = '{6'd12, 6'd60, 6'd20, 6'd8, 6'd63};

  typedef struct {
    bit          cfg_row;
    logic        cfg_idx;
    logic [15:0] cfg_val;
    in_item_t    item;
    bit          typed;
    logic [2:0]  want_kind;
  } script_row_t;

  script_row_t script[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 30));
  endfunction

  function automatic in_item_t byte_item(logic [7:0] b);
    return '{op: OP_BYTE, rx_byte: b};
  endfunction

  function automatic in_item_t tick_item();
    return '{op: OP_TICK, rx_byte: 8'($urandom_range(0, 255))};
  endfunction

  function automatic int line_limit();
    if (line_len_reg < LINE_LEN_MIN) return int'(LINE_LEN_MIN);
    if (int'(line_len_reg) > LINE_CHARS) return LINE_CHARS;
    return int'(line_len_reg);
  endfunction

  function automatic void add_event(logic [2:0] kind, logic [7:0] ch, logic [5:0] col,
                                    logic [5:0] span);
    out_item_t e;
    e.kind = kind;
    e.char_code = ch;
    e.column = col;
    e.span_end = span;
    e.last = 1'b0;
    step_events.push_back(e);
  endfunction

  function automatic void store_char(logic [7:0] c);
    if (int'(line_cursor) < line_limit()) begin
      line_mem[line_cursor] = c;
      line_cursor++;
    end
  endfunction

  function automatic void flush_span(bit ext);
    int j;
    for (j = int'(printed_mark); j < int'(line_cursor) && j < LINE_CHARS; j++)
      add_event(KIND_CHAR, line_mem[j], 6'(j), '0);
    add_event(ext ? KIND_DONE_EXT : KIND_DONE, 8'h00, printed_mark, line_cursor);
    if (!keep_mark) printed_mark = line_cursor;
    else keep_mark = 1'b0;
  endfunction

  // works out the results that one item causes and updates the line state
  task automatic assemble_line(input in_item_t it);
    logic [7:0] b, t;
    bit renew, need_nl, need_cr, print_due;
    int len, target, n, lim;
    b = it.rx_byte;
    renew = 1'b0;
    need_nl = 1'b0;
    need_cr = 1'b0;
    print_due = 1'b0;
    len = line_limit();
    step_events.delete();
    if (it.op == OP_TICK) begin
      if (!line_idle) begin
        lim = (timeout_ticks == 0) ? 1 : int'(timeout_ticks);
        if (quiet_ticks < TICK_SAT) quiet_ticks++;
        if (int'(quiet_ticks) >= lim) begin
          quiet_ticks = '0;
          line_idle = 1'b1;
          flush_span(1'b1);
        end
      end
    end else if (esc_state != ESC_NONE) begin
      if (esc_state == ESC_ONE && (b == BYTE_LPAREN || b == BYTE_RPAREN)) esc_state = ESC_TWO;
      else esc_state = ESC_NONE;
    end else if (skip_left != 0) begin
      skip_left--;
    end else if (b == BYTE_ESC) begin
      esc_state = ESC_ONE;
    end else if (b == BYTE_BS) begin
      if (line_cursor > 0) line_cursor--;
      if (line_cursor < printed_mark) begin
        renew = 1'b1;
        printed_mark = '0;
        need_nl = 1'b1;
        if (line_cursor != 0) keep_mark = 1'b1;
        else lf_guard = 1'b1;
      end
    end else if (b == BYTE_BEL) begin
      add_event(KIND_BEEP, 8'h00, '0, '0);
    end else if (b == BYTE_LF) begin
      renew = 1'b1;
      if (line_cursor != 0 || !lf_guard) begin
        need_nl = 1'b1;
        need_cr = 1'b1;
      end else begin
        lf_guard = 1'b0;
      end
    end else if (b == BYTE_TAB) begin
      target = int'(line_cursor) - int'(line_cursor % 8) + 8;
      renew = 1'b1;
      if (target > len) target = len;
      while (int'(line_cursor) + 1 < target) store_char(BYTE_SPACE);
      store_char(BYTE_TAB);
    end else if (b < BYTE_SPACE) begin
      // remaining control bytes do nothing
    end else if (b >= BYTE_HIGH) begin
      // count of continuation bytes from the lead byte's leading ones
      t = {b[6:0], 1'b0};
      n = 0;
      while (t[7]) begin
        n++;
        t = {t[6:0], 1'b0};
      end
      skip_left = 3'(n);
      renew = 1'b1;
      store_char(BYTE_DEL);
    end else begin
      renew = 1'b1;
      store_char(b);
    end

    if (renew) begin
      quiet_ticks = '0;
      if (line_idle) begin
        line_idle = 1'b0;
        if (need_nl) begin
          keep_mark = 1'b0;
          add_event(KIND_WITHDRAW_ONE, 8'h00, '0, '0);
        end else begin
          add_event(KIND_WITHDRAW, 8'h00, '0, '0);
        end
        need_nl = 1'b0;
      end
      if (lf_guard && line_cursor != 0) lf_guard = 1'b0;
      if (int'(line_cursor) >= len) begin
        print_due = 1'b1;
        need_cr = 1'b1;
        lf_guard = 1'b1;
      end
      if (need_nl) print_due = 1'b1;
      if (print_due) flush_span(1'b0);
      if (need_cr) begin
        printed_mark = '0;
        line_cursor = '0;
      end
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
  endtask

  task automatic offer_item(input in_item_t it, input bit typed, input logic [2:0] typed_kind,
                            output bit ignored);
    out_item_t want;
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    ignored = (it.op == OP_TICK) && line_idle;
    assemble_line(it);
    if (typed) begin
      want = '{kind: typed_kind, char_code: 8'h00, column: '0, span_end: '0, last: 1'b1};
      events_due.push_back(want);
    end else begin
      foreach (step_events[k]) events_due.push_back(step_events[k]);
    end
    gap = fast_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] val);
    settle_block();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDLE_TIMEOUT) timeout_ticks = val;
    else line_len_reg = val[5:0];
    @(posedge clk);
  endtask

  task automatic add_item(input logic op, input logic [7:0] b);
    script.push_back('{cfg_row: 1'b0, cfg_idx: CFG_IDLE_TIMEOUT, cfg_val: '0,
                       item: '{op: op, rx_byte: b}, typed: 1'b0, want_kind: KIND_WITHDRAW});
  endtask

  task automatic add_checked(input logic op, input logic [7:0] b, input logic [2:0] kind);
    script.push_back('{cfg_row: 1'b0, cfg_idx: CFG_IDLE_TIMEOUT, cfg_val: '0,
                       item: '{op: op, rx_byte: b}, typed: 1'b1, want_kind: kind});
  endtask

  task automatic add_cfg(input logic idx, input logic [15:0] val);
    script.push_back('{cfg_row: 1'b1, cfg_idx: idx, cfg_val: val,
                       item: '0, typed: 1'b0, want_kind: KIND_WITHDRAW});
  endtask

  task automatic random_burst(inout int counted);
    in_item_t burst[$];
    int pick, n;
    bit ignored;
    logic [7:0] lead;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(1, 10);
      repeat (n) burst.push_back(byte_item(8'($urandom_range(8'h20, 8'h7F))));
    end else if (pick < 50) begin
      burst.push_back(byte_item(BYTE_TAB));
    end else if (pick < 58) begin
      burst.push_back(byte_item(BYTE_LF));
    end else if (pick < 65) begin
      n = $urandom_range(1, 3);
      repeat (n) burst.push_back(byte_item(BYTE_BS));
    end else if (pick < 74) begin
      n = $urandom_range(1, 8);
      repeat (n) burst.push_back(tick_item());
    end else if (pick < 81) begin
      if ($urandom_range(0, 9) == 0) begin
        // overlong lead byte, followed by anything
        burst.push_back(byte_item(8'($urandom_range(8'hF8, 8'hFF))));
        n = $urandom_range(0, 8);
        repeat (n) burst.push_back(byte_item(8'($urandom_range(0, 255))));
      end else begin
        n = $urandom_range(1, 3);
        if (n == 1) lead = 8'hC0 | 8'($urandom_range(0, 31));
        else if (n == 2) lead = 8'hE0 | 8'($urandom_range(0, 15));
        else lead = 8'hF0 | 8'($urandom_range(0, 7));
        burst.push_back(byte_item(lead));
        repeat (n) burst.push_back(byte_item(8'h80 | 8'($urandom_range(0, 63))));
      end
    end else if (pick < 87) begin
      burst.push_back(byte_item(BYTE_ESC));
      if ($urandom_range(0, 1)) begin
        burst.push_back(byte_item($urandom_range(0, 1) ? BYTE_LPAREN : BYTE_RPAREN));
        burst.push_back(byte_item(8'($urandom_range(0, 255))));
      end else begin
        burst.push_back(byte_item(8'($urandom_range(0, 255))));
      end
    end else if (pick < 90) begin
      burst.push_back(byte_item(BYTE_BEL));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) burst.push_back('{op: 1'($urandom_range(0, 1)),
                                   rx_byte: 8'($urandom_range(0, 255))});
    end
    foreach (burst[k]) begin
      offer_item(burst[k], 1'b0, KIND_WITHDRAW, ignored);
      if (!ignored) counted++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40)
      $display("cycle %0d: item mismatch on %s: got %0d, expected %0d",
               cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // receiver side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_taken <= 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      stall_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (fast_phase || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        report_mismatch("unexpected result kind", int'(out_item.kind), -1);
      end else begin
        head_event = events_due.pop_front();
        if (out_item.kind !== head_event.kind)
          report_mismatch("kind", int'(out_item.kind), int'(head_event.kind));
        if (out_item.char_code !== head_event.char_code)
          report_mismatch("char_code", int'(out_item.char_code), int'(head_event.char_code));
        if (out_item.column !== head_event.column)
          report_mismatch("column", int'(out_item.column), int'(head_event.column));
        if (out_item.span_end !== head_event.span_end)
          report_mismatch("span_end", int'(out_item.span_end), int'(head_event.span_end));
        if (out_item.last !== head_event.last)
          report_mismatch("last", int'(out_item.last), int'(head_event.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int counted;
    bit ignored;

    // first text after reset, then a beep
    add_checked(OP_BYTE, 8'h41, KIND_WITHDRAW);
    add_checked(OP_BYTE, BYTE_BEL, KIND_BEEP);
    add_item(OP_BYTE, BYTE_DEL);
    add_item(OP_BYTE, BYTE_SPACE);
    add_item(OP_BYTE, BYTE_TAB);
    add_item(OP_BYTE, 8'h00);
    add_item(OP_BYTE, 8'h0D);
    // three-byte utf-8 sequence, then a lone continuation byte
    add_item(OP_BYTE, 8'hE2);
    add_item(OP_BYTE, 8'h82);
    add_item(OP_BYTE, 8'hAC);
    add_item(OP_BYTE, BYTE_HIGH);
    // escape swallowing one byte, then two after a paren
    add_item(OP_BYTE, BYTE_ESC);
    add_item(OP_BYTE, 8'h78);
    add_item(OP_BYTE, BYTE_ESC);
    add_item(OP_BYTE, BYTE_LPAREN);
    add_item(OP_BYTE, 8'h42);
    add_item(OP_BYTE, BYTE_BS);
    add_item(OP_BYTE, BYTE_LF);
    // empty line still gets a print done
    add_checked(OP_BYTE, BYTE_LF, KIND_DONE);
    add_cfg(CFG_IDLE_TIMEOUT, 16'd2);
    add_cfg(CFG_LINE_LENGTH, 16'd8);
    add_item(OP_TICK, 8'hFF);
    add_checked(OP_TICK, 8'h00, KIND_DONE_EXT);
    // tick while idle does nothing
    add_item(OP_TICK, 8'hA5);
    add_checked(OP_BYTE, BYTE_LF, KIND_WITHDRAW_ONE);
    // tab fills the whole short line, then the guarded line feed
    add_item(OP_BYTE, BYTE_TAB);
    add_item(OP_BYTE, BYTE_LF);
    add_cfg(CFG_LINE_LENGTH, 16'd63);
    add_item(OP_BYTE, BYTE_TAB);
    add_item(OP_BYTE, BYTE_TAB);
    // line shrinks below the cursor: next char is dropped and the line printed
    add_cfg(CFG_LINE_LENGTH, 16'd5);
    add_item(OP_BYTE, 8'h5A);
    add_item(OP_BYTE, 8'h7E);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < script.size(); i++) begin
      if (script[i].cfg_row) write_register(script[i].cfg_idx, script[i].cfg_val);
      else offer_item(script[i].item, script[i].typed, script[i].want_kind, ignored);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(CFG_IDLE_TIMEOUT, phase_timeout[p]);
      write_register(CFG_LINE_LENGTH, {10'd0, phase_len[p]});
      fast_phase <= (p == 2);
      if (p == 0 || p == 3) hold_asked <= hold_asked + 1;
      counted = 0;
      while (counted < PHASE_ITEMS) random_burst(counted);
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
